>>> src/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
package ddo_pkg;

    // CORDIC iteration count; anything above 32 behaves as 32
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);

    // Starting x of the rotation, 1/K in Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // atan(2^-i) as a binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Wheel deltas of one item, both signed 33-bit
    typedef struct packed {
        logic [32:0] sum;
        logic [32:0] diff;
    } t_delta;

    // Status and results of the sine/cosine unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [33:0] c;
        logic signed [33:0] s;
    } t_trig;

    // Configuration register values
    typedef struct packed {
        logic [31:0] distance_per_tick;
        logic [31:0] angle_per_tick;
    } t_cfg;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        return ATAN_TURNS[idx];
    endfunction

endpackage

>>> src/differential_drive_odometry.sv
// Top level of the differential-drive odometry block.
//
// Input channel: push/full. Each item carries the absolute left and right
// encoder counts; the block differences them against the counts of the
// previous item (modulo 2^32) and updates the pose.
// Result channel: empty/pop. While empty is low the oldest pose (x, y in
// signed Q24.24, heading as a binary angle) is on the result ports.
// Configuration: APB-style port, distance_per_tick at 0x0, angle_per_tick
// at 0x4; pready is always high. Write only while the block is idle.
// Each item runs through the CORDIC, one step per cycle, and makes six
// passes through one shared 32x32 multiplier; the back end starts the
// next item only once it has handed on its result.
// A two-entry queue between the delta front end and the back end lets
// new counts be taken while the back end works or a result waits.
// Reset (synchronous, active low) clears the pose, the stored counts, the
// registers and the queue. When the receiver does not pop, the finished
// pose stays on the ports and the back end stalls before its next result.
module differential_drive_odometry (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    output logic               empty,
    input  logic               pop,
    output logic signed [47:0] o_x_position,
    output logic signed [47:0] o_y_position,
    output logic [31:0]        o_heading,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic REG_DISTANCE_PER_TICK = 1'b0;
    localparam logic REG_ANGLE_PER_TICK    = 1'b1;

    ddo_pkg::t_cfg   cfg;
    logic [31:0]     r_dpt;
    logic [31:0]     r_apt;
    logic            cfg_wr;
    logic            q_full;
    logic            q_push;
    ddo_pkg::t_delta q_in;
    logic            q_empty;
    logic            q_pop;
    ddo_pkg::t_delta q_out;
    logic            trig_start;
    logic [31:0]     trig_angle;
    ddo_pkg::t_trig  trig;
    logic            out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg.distance_per_tick = r_dpt;
    assign cfg.angle_per_tick    = r_apt;
    assign empty = !out_valid;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt <= '0;
            r_apt <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_DISTANCE_PER_TICK: r_dpt <= pwdata;
                REG_ANGLE_PER_TICK:    r_apt <= pwdata;
                default:               r_dpt <= r_dpt;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[2])
            REG_DISTANCE_PER_TICK: prdata = r_dpt;
            REG_ANGLE_PER_TICK:    prdata = r_apt;
            default:               prdata = '0;
        endcase
    end

    ddo_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    ddo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (trig_angle),
        .o_trig  (trig)
    );

    ddo_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_valid     (!q_empty),
        .i_q_item      (q_out),
        .o_q_pop       (q_pop),
        .o_start       (trig_start),
        .o_start_angle (trig_angle),
        .i_trig        (trig),
        .i_pop         (pop),
        .o_valid       (out_valid),
        .o_x_position  (o_x_position),
        .o_y_position  (o_y_position),
        .o_heading     (o_heading)
    );

endmodule

>>> src/ddo_queue.sv
// Small register queue of wheel-delta items between front and back.
module ddo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ddo_pkg::t_delta i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ddo_pkg::t_delta o_item
);

    ddo_pkg::t_delta                r_mem [ddo_pkg::QUEUE_DEPTH];
    logic [ddo_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [ddo_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [ddo_pkg::QCNT_W-1:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == ddo_pkg::QCNT_W'(ddo_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == ddo_pkg::QPTR_W'(ddo_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == ddo_pkg::QPTR_W'(ddo_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> src/ddo_front.sv
// Front part: takes encoder counts and turns them into wheel deltas.
module ddo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic               i_q_full,
    output logic               o_q_push,
    output ddo_pkg::t_delta    o_q_item
);

    logic [31:0] r_last_left;
    logic [31:0] r_last_right;
    logic [31:0] dl;
    logic [31:0] dr;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // deltas modulo 2^32, then sum and difference in 33 bits
    assign dl = i_left_count - r_last_left;
    assign dr = i_right_count - r_last_right;
    assign o_q_item.sum  = {dl[31], dl} + {dr[31], dr};
    assign o_q_item.diff = {dr[31], dr} - {dl[31], dl};

    // previous counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_left  <= '0;
            r_last_right <= '0;
        end else if (o_q_push) begin
            r_last_left  <= i_left_count;
            r_last_right <= i_right_count;
        end
    end

endmodule

>>> src/ddo_cordic.sv
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle, Q2.30.
module ddo_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [31:0]    i_angle,
    output ddo_pkg::t_trig o_trig
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_flip;
    logic [ddo_pkg::ITER_W-1:0] r_idx;
    logic signed [33:0]         r_x;
    logic signed [33:0]         r_y;
    logic signed [33:0]         r_z;
    logic [31:0]                q;
    logic [31:0]                a_fold;
    logic signed [33:0]         sx;
    logic signed [33:0]         sy;
    logic signed [33:0]         atan;
    logic                       last;

    // fold the left half plane onto the right one
    assign q      = i_angle + 32'h4000_0000;
    assign a_fold = {i_angle[31] ^ q[31], i_angle[30:0]};

    assign sx   = r_x >>> r_idx;
    assign sy   = r_y >>> r_idx;
    assign atan = $signed({2'b00, ddo_pkg::atan_lut(5'(r_idx))});
    assign last = (r_idx == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_ITERS - 1));

    assign o_trig.busy = r_busy;
    assign o_trig.done = r_done;
    assign o_trig.c    = r_flip ? -r_x : r_x;
    assign o_trig.s    = r_flip ? -r_y : r_y;

    // one micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_flip <= q[31];
                r_x    <= ddo_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= $signed({{2{a_fold[31]}}, a_fold});
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - sy;
                    r_y <= r_y + sx;
                    r_z <= r_z - atan;
                end else begin
                    r_x <= r_x + sy;
                    r_y <= r_y - sx;
                    r_z <= r_z + atan;
                end
                r_idx <= r_idx + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> src/ddo_back.sv
// Back part: scaling multiplies, heading, CORDIC and pose accumulation.
module ddo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ddo_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  ddo_pkg::t_delta    i_q_item,
    output logic               o_q_pop,
    output logic               o_start,
    output logic [31:0]        o_start_angle,
    input  ddo_pkg::t_trig     i_trig,
    input  logic               i_pop,
    output logic               o_valid,
    output logic signed [47:0] o_x_position,
    output logic signed [47:0] o_y_position,
    output logic [31:0]        o_heading
);

    typedef enum logic [3:0] {
        S_IDLE, S_TURN, S_DIST, S_DSAVE, S_ROT, S_XLO,
        S_XHI, S_YLO, S_YHI, S_YRND, S_YACC, S_DONE
    } t_state;

    t_state       r_state;
    logic [32:0]  r_sum;
    logic [32:0]  r_diff;
    logic [63:0]  r_prod;
    logic [31:0]  r_turn;
    logic [62:0]  r_dist;
    logic         r_neg;
    logic [31:0]  r_cmag;
    logic [31:0]  r_smag;
    logic         r_cneg;
    logic         r_sneg;
    logic [63:0]  r_lo;
    logic [47:0]  r_mag;
    logic [47:0]  r_pos_x;
    logic [47:0]  r_pos_y;
    logic [31:0]  r_angle;
    logic         r_out_valid;
    logic [47:0]  r_out_x;
    logic [47:0]  r_out_y;
    logic [31:0]  r_out_h;

    logic [32:0]  n_ms;
    logic [32:0]  n_turn;
    logic [33:0]  n_cabs;
    logic [33:0]  n_sabs;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;

    // distance product halves rounded to Q24.24, modulo 2^48
    function automatic logic [47:0] round_q30(input logic [63:0] lo, input logic [63:0] hi);
        logic [64:0] t;
        t = {1'b0, lo} + 65'h0_2000_0000;
        return 48'(t[64:30]) + {hi[45:0], 2'b00};
    endfunction

    assign n_ms   = r_sum[32] ? (33'd0 - r_sum) : r_sum;
    assign n_turn = r_prod[32:0] + {r_diff[32] & i_cfg.angle_per_tick[0], 32'd0};
    assign n_cabs = i_trig.c[33] ? (34'd0 - i_trig.c) : i_trig.c;
    assign n_sabs = i_trig.s[33] ? (34'd0 - i_trig.s) : i_trig.s;

    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_start       = (r_state == S_DIST);
    assign o_start_angle = r_angle + n_turn[32:1];

    assign o_valid      = r_out_valid;
    assign o_x_position = $signed(r_out_x);
    assign o_y_position = $signed(r_out_y);
    assign o_heading    = r_out_h;

    // operand select for the shared 32x32 multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_TURN: begin
                mul_a = r_diff[31:0];
                mul_b = i_cfg.angle_per_tick;
            end
            S_DIST: begin
                mul_a = n_ms[31:0];
                mul_b = i_cfg.distance_per_tick;
            end
            S_XLO: begin
                mul_a = r_dist[31:0];
                mul_b = r_cmag;
            end
            S_XHI: begin
                mul_a = {1'b0, r_dist[62:32]};
                mul_b = r_cmag;
            end
            S_YLO: begin
                mul_a = r_dist[31:0];
                mul_b = r_smag;
            end
            S_YHI: begin
                mul_a = {1'b0, r_dist[62:32]};
                mul_b = r_smag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer, pose and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_angle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= mul_a * mul_b;
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_sum   <= i_q_item.sum;
                        r_diff  <= i_q_item.diff;
                        r_state <= S_TURN;
                    end
                end
                S_TURN: r_state <= S_DIST;
                S_DIST: begin
                    r_turn  <= n_turn[31:0];
                    r_state <= S_DSAVE;
                end
                S_DSAVE: begin
                    // |sum| of exactly 2^32 leaves the low product at zero
                    r_dist  <= n_ms[32] ? {i_cfg.distance_per_tick, 31'd0} : r_prod[63:1];
                    r_neg   <= r_sum[32];
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (i_trig.done) begin
                        r_cmag  <= n_cabs[31:0];
                        r_smag  <= n_sabs[31:0];
                        r_cneg  <= i_trig.c[33];
                        r_sneg  <= i_trig.s[33];
                        r_state <= S_XLO;
                    end
                end
                S_XLO: r_state <= S_XHI;
                S_XHI: begin
                    r_lo    <= r_prod;
                    r_state <= S_YLO;
                end
                S_YLO: begin
                    r_mag   <= round_q30(r_lo, r_prod);
                    r_state <= S_YHI;
                end
                S_YHI: begin
                    r_lo    <= r_prod;
                    r_pos_x <= (r_neg ^ r_cneg) ? r_pos_x - r_mag : r_pos_x + r_mag;
                    r_state <= S_YRND;
                end
                S_YRND: begin
                    r_mag   <= round_q30(r_lo, r_prod);
                    r_state <= S_YACC;
                end
                S_YACC: begin
                    r_pos_y <= (r_neg ^ r_sneg) ? r_pos_y - r_mag : r_pos_y + r_mag;
                    r_angle <= r_angle + r_turn;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_x     <= r_pos_x;
                        r_out_y     <= r_pos_y;
                        r_out_h     <= r_angle;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_start |-> !i_trig.busy)
        else $error("CORDIC started while busy");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_trig.done |-> (r_state == S_ROT))
        else $error("CORDIC result arrived outside the wait state");

    a_heading_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_YACC) |=> $stable(r_angle))
        else $error("heading changed outside the commit step");

    a_result_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_pop) |=> (r_state == S_DONE))
        else $error("pending result overwritten");

endmodule
